@@ rtl/core/pdu_pkg.sv @@
package pdu_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned CP_W    = 21;

   localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 16'd16384;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 17'h1ffff;

   // raw and decoded character codes
   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DEL     = 8'h7f;

   // utf-8 lead byte ranges
   localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hc2;
   localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD3_LO = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hf4;

   // code point limits
   localparam logic [CP_W-1:0] CP_MIN3      = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN4      = 21'h010000;
   localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00d800;
   localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00dfff;
   localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_HIGH,
      ESC_LOW
   } esc_phase_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_TOO_LONG   = 3'd1,
      STATUS_BAD_ESCAPE = 3'd2,
      STATUS_CONTROL    = 3'd3,
      STATUS_BAD_UTF8   = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              last;
      logic              plus_means_space;
   } req_word_type;

   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              end_of_string;
      status_type        status;
   } rsp_word_type;

   typedef struct packed {
      logic              feed;
      logic [BYTE_W-1:0] value;
      logic              clear;
   } utf8_ctl_type;

   typedef struct packed {
      logic error;
      logic pending;
   } utf8_stat_type;

   // {valid, nibble} for a hex digit of either case
   function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic is_control(input logic [BYTE_W-1:0] v);
      return (v < CHAR_SPACE) || (v == CHAR_DEL);
   endfunction

endpackage

@@ rtl/core/pdu_in_stage.sv @@
module pdu_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pdu_pkg::req_word_type req_word,
   input  logic                  advance,
   output logic                  stage_valid,
   output pdu_pkg::req_word_type stage_word
);

   logic                  valid_ff;
   logic                  valid_in;
   pdu_pkg::req_word_type word_ff;
   logic                  take;

   // stage frees up whenever its word moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

@@ rtl/core/pdu_utf8_check.sv @@
module pdu_utf8_check (
   input  logic                   clock,
   input  logic                   reset,
   input  pdu_pkg::utf8_ctl_type  ctl,
   output pdu_pkg::utf8_stat_type stat
);

   logic [1:0]               pending_ff, pending_in;
   logic [1:0]               seq_len_ff, seq_len_in;
   logic [pdu_pkg::CP_W-1:0] acc_ff, acc_in;
   logic                     error_ff, error_in;
   logic [pdu_pkg::CP_W-1:0] cp;

   assign cp = {acc_ff[pdu_pkg::CP_W-7:0], ctl.value[5:0]};

   always_comb begin
      pending_in = pending_ff;
      seq_len_in = seq_len_ff;
      acc_in     = acc_ff;
      error_in   = error_ff;
      if (ctl.feed && !error_ff) begin
         if (pending_ff == 2'd0) begin
            if (ctl.value inside {[pdu_pkg::LEAD2_LO:pdu_pkg::LEAD2_HI]}) begin
               seq_len_in = 2'd1;
               pending_in = 2'd1;
               acc_in     = pdu_pkg::CP_W'(ctl.value[4:0]);
            end else if (ctl.value inside {[pdu_pkg::LEAD3_LO:pdu_pkg::LEAD3_HI]}) begin
               seq_len_in = 2'd2;
               pending_in = 2'd2;
               acc_in     = pdu_pkg::CP_W'(ctl.value[3:0]);
            end else if (ctl.value inside {[pdu_pkg::LEAD4_LO:pdu_pkg::LEAD4_HI]}) begin
               seq_len_in = 2'd3;
               pending_in = 2'd3;
               acc_in     = pdu_pkg::CP_W'(ctl.value[2:0]);
            end else if (ctl.value[7]) begin
               // stray continuation, c0/c1 or f5 and up
               error_in = 1'b1;
            end
         end else if (ctl.value[7:6] != 2'b10) begin
            error_in = 1'b1;
         end else begin
            acc_in     = cp;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               if ((seq_len_ff == 2'd2 && cp < pdu_pkg::CP_MIN3) ||
                   (seq_len_ff == 2'd3 && cp < pdu_pkg::CP_MIN4) ||
                   (cp >= pdu_pkg::CP_SURR_LO && cp <= pdu_pkg::CP_SURR_HI) ||
                   (cp > pdu_pkg::CP_MAX)) begin
                  error_in = 1'b1;
               end
               seq_len_in = 2'd0;
               acc_in     = '0;
            end
         end
      end
   end

   assign stat.error   = error_in;
   assign stat.pending = (pending_in != 2'd0);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         pending_ff <= 2'd0;
         seq_len_ff <= 2'd0;
         acc_ff     <= '0;
         error_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         seq_len_ff <= seq_len_in;
         acc_ff     <= acc_in;
         error_ff   <= error_in;
      end
   end

endmodule

@@ rtl/core/pdu_decode_core.sv @@
module pdu_decode_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  pdu_pkg::req_word_type       word,
   input  logic [pdu_pkg::LEN_W-1:0]   max_length,
   output pdu_pkg::utf8_ctl_type       utf8_ctl,
   input  pdu_pkg::utf8_stat_type      utf8_stat,
   output pdu_pkg::rsp_word_type       rsp_word
);

   pdu_pkg::esc_phase_type          escape_ff, escape_in;
   logic [3:0]                      nibble_ff, nibble_in;
   logic [pdu_pkg::COUNT_W-1:0]     count_ff, count_in;
   pdu_pkg::status_type             first_error_ff, first_error_in;
   logic [4:0]                      hex;
   logic                            have;
   logic                            emit;
   logic [pdu_pkg::BYTE_W-1:0]      value;
   pdu_pkg::status_type             status;

   assign hex = pdu_pkg::hex_nibble(word.in_byte);

   always_comb begin
      count_in       = (count_ff == pdu_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
      escape_in      = escape_ff;
      nibble_in      = nibble_ff;
      first_error_in = first_error_ff;
      have           = 1'b0;
      emit           = 1'b0;
      value          = '0;
      if (first_error_ff == pdu_pkg::STATUS_OK) begin
         case (escape_ff)
            pdu_pkg::ESC_NONE: begin
               if (word.in_byte == pdu_pkg::CHAR_PERCENT) begin
                  escape_in = pdu_pkg::ESC_HIGH;
               end else begin
                  value = (word.in_byte == pdu_pkg::CHAR_PLUS && word.plus_means_space) ?
                          pdu_pkg::CHAR_SPACE : word.in_byte;
                  have  = 1'b1;
               end
            end
            pdu_pkg::ESC_HIGH: begin
               if (!hex[4]) begin
                  first_error_in = pdu_pkg::STATUS_BAD_ESCAPE;
                  escape_in      = pdu_pkg::ESC_NONE;
               end else begin
                  nibble_in = hex[3:0];
                  escape_in = pdu_pkg::ESC_LOW;
               end
            end
            pdu_pkg::ESC_LOW: begin
               if (!hex[4]) begin
                  first_error_in = pdu_pkg::STATUS_BAD_ESCAPE;
               end else begin
                  value = {nibble_ff, hex[3:0]};
                  have  = 1'b1;
               end
               escape_in = pdu_pkg::ESC_NONE;
            end
            default: begin
               escape_in = pdu_pkg::ESC_NONE;
            end
         endcase
         if (have) begin
            if (pdu_pkg::is_control(value)) begin
               first_error_in = pdu_pkg::STATUS_CONTROL;
            end else begin
               emit = 1'b1;
            end
         end
         // escape left open at the end of the string
         if (word.last && first_error_in == pdu_pkg::STATUS_OK &&
             escape_in != pdu_pkg::ESC_NONE) begin
            first_error_in = pdu_pkg::STATUS_BAD_ESCAPE;
         end
      end
   end

   always_comb begin
      status = pdu_pkg::STATUS_OK;
      if (word.last) begin
         if (count_in > {1'b0, max_length}) begin
            status = pdu_pkg::STATUS_TOO_LONG;
         end else if (first_error_in != pdu_pkg::STATUS_OK) begin
            status = first_error_in;
         end else if (utf8_stat.error || utf8_stat.pending) begin
            status = pdu_pkg::STATUS_BAD_UTF8;
         end
      end
   end

   assign utf8_ctl.feed  = fire && emit;
   assign utf8_ctl.value = value;
   assign utf8_ctl.clear = fire && word.last;

   assign rsp_word.byte_valid    = emit;
   assign rsp_word.out_byte      = emit ? value : '0;
   assign rsp_word.end_of_string = word.last;
   assign rsp_word.status        = status;

   always_ff @(posedge clock) begin
      if (reset || (fire && word.last)) begin
         escape_ff      <= pdu_pkg::ESC_NONE;
         nibble_ff      <= '0;
         count_ff       <= '0;
         first_error_ff <= pdu_pkg::STATUS_OK;
      end else if (fire) begin
         escape_ff      <= escape_in;
         nibble_ff      <= nibble_in;
         count_ff       <= count_in;
         first_error_ff <= first_error_in;
      end
   end

endmodule

@@ rtl/core/percent_decode_utf8_checker.sv @@
// url percent decoder with strict utf-8 check on the decoded stream
//
// req channel: one encoded byte per word, tlast marks the final byte of a
//   string, tuser selects '+' as space for that byte
// rsp channel: exactly one word per req word, in order; tuser flags a
//   decoded byte in tdata[7:0], tlast marks the end of string and
//   tdata[10:8] then carries the status (0 ok, 1 too long, 2 bad escape,
//   3 control byte, 4 bad utf8), zero otherwise
// csr channel: writes max_length, always ready; write only while idle
//
// latency: a req word accepted at edge n shows on rsp after edge n+1
//   (input register, then one pass of decode logic into the rsp register)
// throughput: one word per clock, set by the single decode/utf-8 pass
// stall: rsp register holds while rsp_tready is low; the input register
//   still takes one more word, then req_tready drops until rsp drains
// reset: both channels empty, string state cleared, max_length = 16384
module percent_decode_utf8_checker (
   input  logic        clock,
   input  logic        reset,
   // encoded input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // last
   input  logic        req_tuser,   // plus_means_space
   // decoded output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], status[10:8], zero fill
   output logic        rsp_tlast,   // end_of_string
   output logic        rsp_tuser,   // byte_valid
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // max_length
);

   pdu_pkg::req_word_type         req_word;
   pdu_pkg::req_word_type         stage_word;
   logic                          stage_valid;
   logic                          advance;
   logic                          fire;
   logic [pdu_pkg::LEN_W-1:0]     max_length_ff;
   pdu_pkg::utf8_ctl_type         utf8_ctl;
   pdu_pkg::utf8_stat_type        utf8_stat;
   pdu_pkg::rsp_word_type         rsp_word;
   pdu_pkg::rsp_word_type         rsp_word_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   assign req_word.in_byte          = req_tdata;
   assign req_word.last             = req_tlast;
   assign req_word.plus_means_space = req_tuser;

   // max_length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= pdu_pkg::MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         max_length_ff <= csr_data;
      end
   end

   // rsp register can load when empty or being drained
   assign advance      = !rsp_valid_ff || rsp_tready;
   assign fire         = stage_valid && advance;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   pdu_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_word    (req_word),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_word  (stage_word)
   );

   pdu_decode_core u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .word       (stage_word),
      .max_length (max_length_ff),
      .utf8_ctl   (utf8_ctl),
      .utf8_stat  (utf8_stat),
      .rsp_word   (rsp_word)
   );

   pdu_utf8_check u_utf8 (
      .clock (clock),
      .reset (reset),
      .ctl   (utf8_ctl),
      .stat  (utf8_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_word_ff.status, rsp_word_ff.out_byte};
   assign rsp_tlast  = rsp_word_ff.end_of_string;
   assign rsp_tuser  = rsp_word_ff.byte_valid;

endmodule

@@ rtl/core/pdu_checker.sv @@
module pdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // a status only ever appears on the end of a string, and stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[10:8] == pdu_pkg::STATUS_OK) || rsp_tlast) &&
                     (rsp_tdata[10:8] <= pdu_pkg::STATUS_BAD_UTF8))
      else $error("status outside end of string or out of range");

   // no byte flagged means a zero data byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[7:0] == 8'h00))
      else $error("data byte without byte_valid");

   // an emitted byte is never a control byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[7:0] >= pdu_pkg::CHAR_SPACE) && (rsp_tdata[7:0] != pdu_pkg::CHAR_DEL))
      else $error("control byte emitted");

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed under stall");

endmodule

bind percent_decode_utf8_checker pdu_checker u_pdu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
